[src/emg_window_time_features_assert.svh]
// Assertion macros shared by the checker of emg_window_time_features.
// Each macro expects clk and rst_n in scope.
`ifndef EMG_WINDOW_TIME_FEATURES_ASSERT_SVH
`define EMG_WINDOW_TIME_FEATURES_ASSERT_SVH

// same-cycle implication
`define EMGTF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("emgtf check failed");

// next-cycle implication
`define EMGTF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("emgtf check failed");

`endif

[src/emgtf_pkg.sv]
// Shared constants and controller/datapath interface types for the EMG feature block.
// No dependencies.
package emgtf_pkg;

    localparam int MAX_WINDOW  = 256;
    localparam int SAMPLE_BITS = 16;
    localparam int RING_AW     = 8;
    localparam int CNT_W       = 9;
    localparam int DIV_W       = 48;
    localparam int DVS_W       = 17;
    localparam int SQ_W        = 48;
    localparam int ROOT_W      = 24;

    localparam logic [1:0] SEL_MEANSQ = 2'd0;
    localparam logic [1:0] SEL_VAR    = 2'd1;
    localparam logic [1:0] SEL_MEANAB = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       walk;
        logic       mul1;
        logic       mul2;
        logic       vsub;
        logic       div_start;
        logic       div_wait;
        logic       sqrt_start;
        logic       sqrt_wait;
        logic [1:0] sel;
        logic       out_load;
    } emgtf_cmd_t;

    typedef struct packed {
        logic emit;
        logic walk_done;
        logic div_done;
        logic sqrt_done;
    } emgtf_stat_t;

endpackage

[src/emgtf_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on emgtf_pkg.
module emgtf_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [emgtf_pkg::DIV_W-1:0] dividend,
    input  logic [emgtf_pkg::DVS_W-1:0] divisor,
    output logic [emgtf_pkg::DIV_W-1:0] quotient,
    output logic                        done
);
    import emgtf_pkg::*;

    logic [DIV_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   trial;
    logic             ge;
    logic [DVS_W-1:0] rem_next;

    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign ge       = trial >= {1'b0, dvs_reg};
    assign rem_next = ge ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 6'(DIV_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;
endmodule

[src/emgtf_sqrt.sv]
// Floor square root, two operand bits per cycle.
// Depends on emgtf_pkg.
module emgtf_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [emgtf_pkg::SQ_W-1:0]   value,
    output logic [emgtf_pkg::ROOT_W-1:0] root,
    output logic                         done
);
    import emgtf_pkg::*;

    logic [SQ_W-1:0]   op_reg;
    logic [ROOT_W:0]   rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [ROOT_W+2:0] remsh;
    logic [ROOT_W+2:0] trial;
    logic              ge;

    assign remsh = {rem_reg, op_reg[SQ_W-1:SQ_W-2]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign ge    = remsh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 5'(ROOT_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg   <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            op_reg   <= {op_reg[SQ_W-3:0], 2'b00};
            rem_reg  <= ge ? (ROOT_W+1)'(remsh - trial) : remsh[ROOT_W:0];
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign root = root_reg;
    assign done = done_reg;
endmodule

[src/emgtf_datapath.sv]
// Datapath: sample ring, window walk accumulators, variance products, divider and root.
// Depends on emgtf_pkg, emgtf_div, emgtf_sqrt.
module emgtf_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  emgtf_pkg::emgtf_cmd_t               cmd,
    output emgtf_pkg::emgtf_stat_t              stat,
    input  logic [8:0]                          window_length,
    input  logic [8:0]                          hop_length,
    input  logic [15:0]                         amplitude_threshold,
    input  logic signed [emgtf_pkg::SAMPLE_BITS-1:0] sample,
    output logic [15:0]                         rms_amplitude,
    output logic [23:0]                         waveform_length_sum,
    output logic [15:0]                         standard_deviation,
    output logic [15:0]                         mean_absolute,
    output logic [15:0]                         minimum_absolute,
    output logic [15:0]                         maximum_absolute,
    output logic [7:0]                          zero_cross_count,
    output logic [7:0]                          slope_change_count,
    output logic [7:0]                          willison_count
);
    import emgtf_pkg::*;

    logic [SAMPLE_BITS-1:0] ring [MAX_WINDOW];

    logic [RING_AW-1:0] wp_reg;
    logic [CNT_W-1:0]   hop_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [RING_AW-1:0] start_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic               rd_vld_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] h_eff;
    logic [CNT_W-1:0] hop_next;
    logic [CNT_W-1:0] fill_next;
    logic [RING_AW-1:0] rd_addr;

    // accumulators
    logic signed [23:0] sum_reg;
    logic [38:0]        sumsq_reg;
    logic [23:0]        sumabs_reg;
    logic [23:0]        wfl_reg;
    logic [16:0]        min_reg;
    logic [16:0]        max_reg;
    logic [7:0]         zc_reg;
    logic [7:0]         ssc_reg;
    logic [7:0]         wamp_reg;
    logic signed [16:0] prev_reg;
    logic signed [16:0] prevd_reg;

    logic signed [15:0] x;
    logic signed [16:0] x_ext;
    logic [16:0]        a;
    logic signed [16:0] d;
    logic [16:0]        ad;
    logic signed [31:0] xsq;

    // post-walk
    logic [23:0] sum_mag;
    logic [47:0] sq_reg;
    logic [28:0] lo_reg;
    logic [16:0] nn_reg;
    logic [47:0] lhs_reg;
    logic [27:0] hi_prod;
    logic [47:0] var_reg;
    logic [47:0] q_ms_reg;
    logic [47:0] q_var_reg;
    logic [15:0] mean_reg;
    logic [15:0] rms_reg;
    logic [15:0] sd_reg;

    logic [DIV_W-1:0]  div_dnd;
    logic [DVS_W-1:0]  div_dvs;
    logic [DIV_W-1:0]  div_q;
    logic              div_done;
    logic [SQ_W-1:0]   sq_in;
    logic [ROOT_W-1:0] sq_root;
    logic              sq_done;

    // effective window and hop
    always_comb
    begin
        if (window_length < 9'd2)
            n_eff = 9'd2;
        else if (window_length > 9'(MAX_WINDOW))
            n_eff = 9'(MAX_WINDOW);
        else
            n_eff = window_length;
        if (hop_length == 9'd0)
            h_eff = 9'd1;
        else if (hop_length > n_eff)
            h_eff = n_eff;
        else
            h_eff = hop_length;
    end

    assign hop_next  = (hop_reg == 9'd511) ? hop_reg : hop_reg + 9'd1;
    assign fill_next = (fill_reg == 9'(MAX_WINDOW)) ? fill_reg : fill_reg + 9'd1;

    assign stat.emit      = (fill_next >= n_eff) && (hop_next >= h_eff);
    assign stat.walk_done = (idx_reg == n_reg) && rd_vld_reg;
    assign stat.div_done  = div_done;
    assign stat.sqrt_done = sq_done;

    assign rd_addr = start_reg + idx_reg[RING_AW-1:0];

    // ring memory
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            ring[wp_reg] <= sample;
        rd_data_reg <= ring[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= '0;
            hop_reg    <= '0;
            fill_reg   <= '0;
            n_reg      <= 9'd2;
            start_reg  <= '0;
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                wp_reg   <= wp_reg + 8'd1;
                fill_reg <= fill_next;
                hop_reg  <= stat.emit ? 9'd0 : hop_next;
                if (stat.emit)
                begin
                    n_reg      <= n_eff;
                    start_reg  <= wp_reg + 8'd1 - n_eff[RING_AW-1:0];
                    idx_reg    <= '0;
                    rd_vld_reg <= 1'b0;
                    cnt_reg    <= '0;
                end
            end
            else if (cmd.walk)
            begin
                if (idx_reg < n_reg)
                    idx_reg <= idx_reg + 9'd1;
                rd_vld_reg <= idx_reg < n_reg;
                if (rd_vld_reg)
                    cnt_reg <= cnt_reg + 9'd1;
            end
            else
            begin
                rd_vld_reg <= 1'b0;
            end
        end
    end

    // per-sample terms
    assign x     = signed'(rd_data_reg);
    assign x_ext = {x[15], x};
    assign a     = x_ext[16] ? 17'(-x_ext) : 17'(x_ext);
    assign d     = x_ext - prev_reg;
    assign ad    = d[16] ? 17'(-d) : 17'(d);
    assign xsq   = x * x;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sum_reg    <= '0;
            sumsq_reg  <= '0;
            sumabs_reg <= '0;
            wfl_reg    <= '0;
            zc_reg     <= '0;
            ssc_reg    <= '0;
            wamp_reg   <= '0;
        end
        else if (cmd.walk && rd_vld_reg)
        begin
            sum_reg    <= sum_reg + {{8{x[15]}}, x};
            sumsq_reg  <= sumsq_reg + 39'(unsigned'(xsq));
            sumabs_reg <= sumabs_reg + 24'(a);
            if (cnt_reg == 9'd0 || a < min_reg)
                min_reg <= a;
            if (cnt_reg == 9'd0 || a > max_reg)
                max_reg <= a;
            if (cnt_reg != 9'd0)
            begin
                wfl_reg <= wfl_reg + 24'(ad);
                if ((prev_reg < 17'sd0 && x_ext > 17'sd0) ||
                    (prev_reg > 17'sd0 && x_ext < 17'sd0))
                    zc_reg <= zc_reg + 8'd1;
                if (ad > 17'(amplitude_threshold))
                    wamp_reg <= wamp_reg + 8'd1;
                if (cnt_reg >= 9'd2 &&
                    ((prevd_reg < 17'sd0 && d > 17'sd0) ||
                     (prevd_reg > 17'sd0 && d < 17'sd0)))
                    ssc_reg <= ssc_reg + 8'd1;
                prevd_reg <= d;
            end
            prev_reg <= x_ext;
        end
    end

    // variance numerator N*sumsq - sum^2, sumsq split into two partial products
    assign sum_mag = sum_reg[23] ? 24'(-sum_reg) : 24'(sum_reg);
    assign hi_prod = n_reg * sumsq_reg[38:20];

    always_ff @(posedge clk)
    begin
        if (cmd.mul1)
        begin
            sq_reg <= sum_mag * sum_mag;
            lo_reg <= n_reg * sumsq_reg[19:0];
            nn_reg <= n_reg * n_reg;
        end
        if (cmd.mul2)
            lhs_reg <= {hi_prod[27:0], 20'd0} + 48'(lo_reg);
        if (cmd.vsub)
            var_reg <= (lhs_reg > sq_reg) ? lhs_reg - sq_reg : 48'd0;
    end

    // shared divider
    always_comb
    begin
        case (cmd.sel)
            SEL_MEANSQ:
            begin
                div_dnd = 48'(sumsq_reg);
                div_dvs = 17'(n_reg);
            end
            SEL_VAR:
            begin
                div_dnd = var_reg;
                div_dvs = nn_reg;
            end
            SEL_MEANAB:
            begin
                div_dnd = 48'(sumabs_reg);
                div_dvs = 17'(n_reg);
            end
            default:
            begin
                div_dnd = 48'(sumabs_reg);
                div_dvs = 17'(n_reg);
            end
        endcase
    end

    emgtf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dnd),
        .divisor  (div_dvs),
        .quotient (div_q),
        .done     (div_done)
    );

    assign sq_in = (cmd.sel == SEL_VAR) ? q_var_reg : q_ms_reg;

    emgtf_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.sqrt_start),
        .value (sq_in),
        .root  (sq_root),
        .done  (sq_done)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.div_wait && div_done)
        begin
            case (cmd.sel)
                SEL_MEANSQ: q_ms_reg  <= div_q;
                SEL_VAR:    q_var_reg <= div_q;
                default:    mean_reg  <= div_q[15:0];
            endcase
        end
        if (cmd.sqrt_wait && sq_done)
        begin
            if (cmd.sel == SEL_VAR)
                sd_reg <= sq_root[15:0];
            else
                rms_reg <= sq_root[15:0];
        end
        if (cmd.out_load)
        begin
            rms_amplitude       <= rms_reg;
            waveform_length_sum <= wfl_reg;
            standard_deviation  <= sd_reg;
            mean_absolute       <= mean_reg;
            minimum_absolute    <= min_reg[15:0];
            maximum_absolute    <= max_reg[15:0];
            zero_cross_count    <= zc_reg;
            slope_change_count  <= ssc_reg;
            willison_count      <= wamp_reg;
        end
    end
endmodule

[src/emgtf_ctrl.sv]
// Sequencer for the EMG feature block: walk, products, three divides, two roots, output.
// Depends on emgtf_pkg.
module emgtf_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  emgtf_pkg::emgtf_stat_t stat,
    output emgtf_pkg::emgtf_cmd_t  cmd
);
    import emgtf_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_WALK = 4'd1;
    localparam logic [3:0] S_MUL1 = 4'd2;
    localparam logic [3:0] S_MUL2 = 4'd3;
    localparam logic [3:0] S_VSUB = 4'd4;
    localparam logic [3:0] S_D1S  = 4'd5;
    localparam logic [3:0] S_D1W  = 4'd6;
    localparam logic [3:0] S_D2S  = 4'd7;
    localparam logic [3:0] S_D2W  = 4'd8;
    localparam logic [3:0] S_D3S  = 4'd9;
    localparam logic [3:0] S_D3W  = 4'd10;
    localparam logic [3:0] S_R1S  = 4'd11;
    localparam logic [3:0] S_R1W  = 4'd12;
    localparam logic [3:0] S_R2S  = 4'd13;
    localparam logic [3:0] S_R2W  = 4'd14;
    localparam logic [3:0] S_DONE = 4'd15;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        cmd        = '0;
        cmd.sel    = SEL_MEANSQ;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && stat.emit)
                    state_next = S_WALK;
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.walk_done)
                    state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_VSUB;
            end
            S_VSUB:
            begin
                cmd.vsub   = 1'b1;
                state_next = S_D1S;
            end
            S_D1S:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_D1W;
            end
            S_D1W:
            begin
                cmd.div_wait = 1'b1;
                if (stat.div_done)
                    state_next = S_D2S;
            end
            S_D2S:
            begin
                cmd.sel       = SEL_VAR;
                cmd.div_start = 1'b1;
                state_next    = S_D2W;
            end
            S_D2W:
            begin
                cmd.sel      = SEL_VAR;
                cmd.div_wait = 1'b1;
                if (stat.div_done)
                    state_next = S_D3S;
            end
            S_D3S:
            begin
                cmd.sel       = SEL_MEANAB;
                cmd.div_start = 1'b1;
                state_next    = S_D3W;
            end
            S_D3W:
            begin
                cmd.sel      = SEL_MEANAB;
                cmd.div_wait = 1'b1;
                if (stat.div_done)
                    state_next = S_R1S;
            end
            S_R1S:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_R1W;
            end
            S_R1W:
            begin
                cmd.sqrt_wait = 1'b1;
                if (stat.sqrt_done)
                    state_next = S_R2S;
            end
            S_R2S:
            begin
                cmd.sel        = SEL_VAR;
                cmd.sqrt_start = 1'b1;
                state_next     = S_R2W;
            end
            S_R2W:
            begin
                cmd.sel       = SEL_VAR;
                cmd.sqrt_wait = 1'b1;
                if (stat.sqrt_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

[src/emg_window_time_features.sv]
// EMG sliding-window time-domain features. Each accepted input word is one signed
// sample written into a 256-entry ring. A word that completes a hop on a full window
// starts a pass that reads the window oldest to newest, one sample per cycle from the
// ring's registered read port, then forms N*sum(x^2)-sum(x)^2 through the product,
// partial-sum and subtraction states, runs three divides on one shared restoring
// divider (mean square, variance, mean absolute), then two square roots, and loads
// the output word; no new sample is taken until the pass ends. A word that causes no
// result leaves the block ready for the next word. A new sample is taken while a
// finished output word waits to be read; a pass that finishes before that word is
// read waits in its done state until it is.
// Configuration (APB, 32-bit data, pready tied high): 0x0 window_length,
// 0x4 hop_length, 0x8 amplitude_threshold; reads return the stored value.
// Depends on emgtf_pkg, emgtf_ctrl, emgtf_datapath.
module emg_window_time_features (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // sample input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic signed [emgtf_pkg::SAMPLE_BITS-1:0] sample,
    // feature output
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] rms_amplitude,
    output logic [23:0] waveform_length_sum,
    output logic [15:0] standard_deviation,
    output logic [15:0] mean_absolute,
    output logic [15:0] minimum_absolute,
    output logic [15:0] maximum_absolute,
    output logic [7:0]  zero_cross_count,
    output logic [7:0]  slope_change_count,
    output logic [7:0]  willison_count
);
    import emgtf_pkg::*;

    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_HOP    = 2'd1;
    localparam logic [1:0] REG_THRESH = 2'd2;

    logic [8:0]  wl_reg;
    logic [8:0]  hl_reg;
    logic [15:0] thr_reg;
    logic        cfg_wr;

    emgtf_cmd_t  cmd;
    emgtf_stat_t stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // register file; writes land on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg  <= 9'd256;
            hl_reg  <= 9'd128;
            thr_reg <= 16'd16;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_WINDOW: wl_reg  <= pwdata[8:0];
                REG_HOP:    hl_reg  <= pwdata[8:0];
                REG_THRESH: thr_reg <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_WINDOW: prdata = 32'(wl_reg);
            REG_HOP:    prdata = 32'(hl_reg);
            REG_THRESH: prdata = 32'(thr_reg);
            default:    prdata = 32'd0;
        endcase
    end

    emgtf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    emgtf_datapath u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .stat                (stat),
        .window_length       (wl_reg),
        .hop_length          (hl_reg),
        .amplitude_threshold (thr_reg),
        .sample              (sample),
        .rms_amplitude       (rms_amplitude),
        .waveform_length_sum (waveform_length_sum),
        .standard_deviation  (standard_deviation),
        .mean_absolute       (mean_absolute),
        .minimum_absolute    (minimum_absolute),
        .maximum_absolute    (maximum_absolute),
        .zero_cross_count    (zero_cross_count),
        .slope_change_count  (slope_change_count),
        .willison_count      (willison_count)
    );
endmodule

[src/emgtf_checker.sv]
// Port-level checks for emg_window_time_features, bound to the top level.
// Depends on emg_window_time_features_assert.svh.
`include "emg_window_time_features_assert.svh"

module emgtf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] rms_amplitude,
    input logic [15:0] mean_absolute,
    input logic [15:0] minimum_absolute,
    input logic [15:0] maximum_absolute
);
    // output valid held while stalled
    `EMGTF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    // extremes ordered
    `EMGTF_ASSERT_NOW(a_min_max, out_valid, minimum_absolute <= maximum_absolute)
    // mean of magnitudes lies between the extremes
    `EMGTF_ASSERT_NOW(a_mean_rng, out_valid,
        mean_absolute >= minimum_absolute && mean_absolute <= maximum_absolute)
    // rms never below the mean magnitude
    `EMGTF_ASSERT_NOW(a_rms_mean, out_valid, rms_amplitude >= mean_absolute)
endmodule

bind emg_window_time_features emgtf_checker u_chk (.*);
